// File: src/rpd_pkg.sv
// Shared types and constants for the RC PWM pulse decoder.
package rpd_pkg;

    // Channel numbering and the main-tick walk length.
    localparam int NUM_CH        = 5;
    localparam int MAIN_CHANNELS = 4;
    localparam int WALK_CH       = (MAIN_CHANNELS < 4) ? MAIN_CHANNELS : 4;
    localparam logic [2:0] CH_ROLL     = 3'd0;
    localparam logic [2:0] CH_PITCH    = 3'd1;
    localparam logic [2:0] CH_YAW      = 3'd2;
    localparam logic [2:0] CH_THROTTLE = 3'd3;
    localparam logic [2:0] CH_HOLD     = 3'd4;

    // Operation codes of an input word.
    localparam logic [1:0] OP_MAIN_TICK = 2'd0;
    localparam logic [1:0] OP_HOLD_TICK = 2'd1;
    localparam logic [1:0] OP_CAPTURE   = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BAND_HALF     = 3'd0;
    localparam logic [2:0] CFG_PERIOD_TOP    = 3'd1;
    localparam logic [2:0] CFG_PULSE_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_MIN_PULSE     = 3'd3;
    localparam logic [2:0] CFG_MAX_PULSE     = 3'd4;
    localparam logic [2:0] CFG_CENTER_PULSE  = 3'd5;
    localparam logic [2:0] CFG_HOLD_FAILSAFE = 3'd6;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [8:0]  RST_BAND_HALF     = 9'd40;
    localparam logic [15:0] RST_PERIOD_TOP    = 16'd19999;
    localparam logic [7:0]  RST_PULSE_OFFSET  = 8'd20;
    localparam logic [15:0] RST_MIN_PULSE     = 16'd1000;
    localparam logic [15:0] RST_MAX_PULSE     = 16'd2000;
    localparam logic [15:0] RST_CENTER_PULSE  = 16'd1500;
    localparam logic [15:0] RST_HOLD_FAILSAFE = 16'd1100;
    localparam logic [1:0]  RST_TIMEOUT_TICKS = 2'd2;

    // Reset values of the channel outputs.
    localparam logic [15:0] RST_CH_VALUE       = 16'd1500;
    localparam logic [15:0] RST_THROTTLE_VALUE = 16'd1000;

    // Input word: one tick or capture event.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  channel;
        logic        level_high;
        logic [15:0] capture_time;
    } t_in_word;

    // Output word: all five channel values.
    typedef struct packed {
        logic [15:0] roll_value;
        logic [15:0] pitch_value;
        logic [15:0] yaw_value;
        logic [15:0] throttle_value;
        logic [15:0] hold_value;
    } t_out_word;

    // Configuration register set.
    typedef struct packed {
        logic [8:0]  band_half;
        logic [15:0] period_top;
        logic [7:0]  pulse_offset;
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
        logic [15:0] center_pulse;
        logic [15:0] hold_failsafe;
        logic [1:0]  timeout_ticks;
    } t_cfg;

endpackage

// File: src/rc_pwm_pulse_decoder.sv
// Top level of the RC PWM pulse decoder with failsafe.
//
//   Channel  Signals                                       Carries
//   in       i_in_valid, o_in_stall, i_in_word             tick or capture event word
//   out      o_out_valid, i_out_stall, o_out_word          all five channel values
//   cfg      i_cfg_valid, o_cfg_ready, i_cfg_index/data    configuration register write
//
// A word is captured into the input register, updated against the channel
// state in one pass and lands in the result register. One word per cycle is
// sustained while the output does not stall, set by the single update pass per word.
// Reset is synchronous and restores the register defaults and channel values.
// While a result waits on a stalled output the input register holds one more
// word, and then the input stalls until the result leaves.
// Configuration writes are always ready.
module rc_pwm_pulse_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rpd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpd_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic              r_in_valid;
    rpd_pkg::t_in_word r_in_word;
    logic              fire;
    logic              in_accept;
    logic              out_free;
    rpd_pkg::t_cfg     cfg;
    rpd_pkg::t_out_word result;

    assign o_cfg_ready = 1'b1;

    // A word is processed when the result register can take its result.
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    rpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    rpd_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_word  (result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_word  (o_out_word)
    );

endmodule

// File: src/rpd_cfg_regs.sv
// Configuration register file of the RC PWM pulse decoder.
module rpd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output rpd_pkg::t_cfg o_cfg
);

    rpd_pkg::t_cfg r_cfg;
    rpd_pkg::t_cfg n_cfg;

    // Decode a write into the addressed register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpd_pkg::CFG_BAND_HALF:     n_cfg.band_half     = i_cfg_data[8:0];
                rpd_pkg::CFG_PERIOD_TOP:    n_cfg.period_top    = i_cfg_data;
                rpd_pkg::CFG_PULSE_OFFSET:  n_cfg.pulse_offset  = i_cfg_data[7:0];
                rpd_pkg::CFG_MIN_PULSE:     n_cfg.min_pulse     = i_cfg_data;
                rpd_pkg::CFG_MAX_PULSE:     n_cfg.max_pulse     = i_cfg_data;
                rpd_pkg::CFG_CENTER_PULSE:  n_cfg.center_pulse  = i_cfg_data;
                rpd_pkg::CFG_HOLD_FAILSAFE: n_cfg.hold_failsafe = i_cfg_data;
                rpd_pkg::CFG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg_data[1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    // Registers come out of reset at their documented defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_half     <= rpd_pkg::RST_BAND_HALF;
            r_cfg.period_top    <= rpd_pkg::RST_PERIOD_TOP;
            r_cfg.pulse_offset  <= rpd_pkg::RST_PULSE_OFFSET;
            r_cfg.min_pulse     <= rpd_pkg::RST_MIN_PULSE;
            r_cfg.max_pulse     <= rpd_pkg::RST_MAX_PULSE;
            r_cfg.center_pulse  <= rpd_pkg::RST_CENTER_PULSE;
            r_cfg.hold_failsafe <= rpd_pkg::RST_HOLD_FAILSAFE;
            r_cfg.timeout_ticks <= rpd_pkg::RST_TIMEOUT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/rpd_core.sv
// Channel state and single-pass update logic of the RC PWM pulse decoder.
module rpd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rpd_pkg::t_in_word i_word,
    input  rpd_pkg::t_cfg     i_cfg,
    output rpd_pkg::t_out_word o_result
);

    // 2^18 / 25 rounded up; exact for a 14-bit dividend.
    localparam logic [13:0] DIV25_RECIP = 14'd10486;

    logic [15:0] r_rise   [rpd_pkg::NUM_CH];
    logic [15:0] r_value  [rpd_pkg::NUM_CH];
    logic [1:0]  r_missed [rpd_pkg::NUM_CH];
    logic [15:0] r_excess;

    logic [15:0] n_rise   [rpd_pkg::NUM_CH];
    logic [15:0] n_value  [rpd_pkg::NUM_CH];
    logic [1:0]  n_missed [rpd_pkg::NUM_CH];
    logic [15:0] n_excess;

    // Floor of x / 100, done as (x / 4) times the reciprocal of 25.
    function automatic logic [9:0] div100(input logic [15:0] x);
        logic [27:0] prod;
        prod = 28'(x[15:2]) * 28'(DIV25_RECIP);
        return prod[27:18];
    endfunction

    // Dead band about center c, then clamp to the pulse limits.
    function automatic logic [15:0] shape(input logic [15:0] v, input logic [15:0] c,
                                          input rpd_pkg::t_cfg cfg);
        logic [16:0] d;
        logic [16:0] r;
        d = 17'(cfg.band_half);
        if (17'(v) > 17'(c) + d) begin
            r = 17'(v) - d;
        end else if (17'(c) >= d && 17'(v) < 17'(c) - d) begin
            r = 17'(v) + d;
        end else begin
            r = 17'(c);
        end
        if (r < 17'(cfg.min_pulse)) begin
            r = 17'(cfg.min_pulse);
        end else if (r > 17'(cfg.max_pulse)) begin
            r = 17'(cfg.max_pulse);
        end
        return r[15:0];
    endfunction

    // Failsafe throttle step: saturating subtract, then floor at min_pulse.
    function automatic logic [15:0] lower(input logic [15:0] th, input logic [9:0] step,
                                          input logic [15:0] floor_val);
        logic [15:0] t;
        t = (th >= 16'(step)) ? th - 16'(step) : 16'd0;
        return (t < floor_val) ? floor_val : t;
    endfunction

    logic [15:0] th;
    logic [9:0]  step;
    logic        any_timeout;
    logic [15:0] width;
    logic [15:0] adj;
    logic [15:0] rise_sel;

    // Next-state logic for one word.
    always_comb begin
        n_rise      = r_rise;
        n_value     = r_value;
        n_missed    = r_missed;
        n_excess    = r_excess;
        th          = r_value[rpd_pkg::CH_THROTTLE];
        step        = div100(r_excess);
        any_timeout = 1'b0;
        rise_sel    = r_rise[i_word.channel];
        width       = '0;
        adj         = '0;

        unique case (i_word.opcode)
            rpd_pkg::OP_MAIN_TICK: begin
                // Walk the main channels in order; throttle steps down once per
                // timed-out channel, and the excess is saved at throttle if it has not timed out.
                for (int i = 0; i < rpd_pkg::WALK_CH; i++) begin
                    if (r_missed[i] >= i_cfg.timeout_ticks) begin
                        th          = lower(th, step, i_cfg.min_pulse);
                        any_timeout = 1'b1;
                    end else begin
                        n_missed[i] = r_missed[i] + 2'd1;
                        if (i == int'(rpd_pkg::CH_THROTTLE)) begin
                            n_excess = (th >= i_cfg.min_pulse) ? th - i_cfg.min_pulse
                                                               : 16'd0;
                        end
                    end
                end
                n_value[rpd_pkg::CH_THROTTLE] = th;
                if (any_timeout) begin
                    n_value[rpd_pkg::CH_ROLL]  = i_cfg.center_pulse;
                    n_value[rpd_pkg::CH_PITCH] = i_cfg.center_pulse;
                    n_value[rpd_pkg::CH_YAW]   = i_cfg.center_pulse;
                end
            end
            rpd_pkg::OP_HOLD_TICK: begin
                if (r_missed[rpd_pkg::CH_HOLD] >= i_cfg.timeout_ticks) begin
                    n_value[rpd_pkg::CH_HOLD] = i_cfg.hold_failsafe;
                end else begin
                    n_missed[rpd_pkg::CH_HOLD] = r_missed[rpd_pkg::CH_HOLD] + 2'd1;
                end
            end
            rpd_pkg::OP_CAPTURE: begin
                // Rising edge stores the time; falling edge measures the pulse.
                if (i_word.channel <= rpd_pkg::CH_HOLD) begin
                    if (i_word.level_high) begin
                        n_rise[i_word.channel] = i_word.capture_time;
                    end else begin
                        if (i_word.capture_time > rise_sel) begin
                            width = i_word.capture_time - rise_sel;
                        end else begin
                            width = i_cfg.period_top + i_word.capture_time - rise_sel;
                        end
                        adj = width - 16'(i_cfg.pulse_offset);
                        if (i_word.channel == rpd_pkg::CH_HOLD) begin
                            n_value[i_word.channel] = width;
                        end else if (i_word.channel == rpd_pkg::CH_THROTTLE) begin
                            n_value[i_word.channel] = shape(width, i_cfg.min_pulse, i_cfg);
                        end else begin
                            n_value[i_word.channel] = shape(adj, i_cfg.center_pulse, i_cfg);
                        end
                        n_missed[i_word.channel] = 2'd0;
                    end
                end
            end
            default: begin
                n_rise = r_rise;
            end
        endcase
    end

    // State registers move only when a word is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rpd_pkg::NUM_CH; i++) begin
                r_rise[i]   <= '0;
                r_value[i]  <= (i == int'(rpd_pkg::CH_THROTTLE)) ?
                               rpd_pkg::RST_THROTTLE_VALUE : rpd_pkg::RST_CH_VALUE;
                r_missed[i] <= '0;
            end
            r_excess <= '0;
        end else if (i_fire) begin
            r_rise   <= n_rise;
            r_value  <= n_value;
            r_missed <= n_missed;
            r_excess <= n_excess;
        end
    end

    // The result of a word is the channel set after its update.
    assign o_result.roll_value     = n_value[rpd_pkg::CH_ROLL];
    assign o_result.pitch_value    = n_value[rpd_pkg::CH_PITCH];
    assign o_result.yaw_value      = n_value[rpd_pkg::CH_YAW];
    assign o_result.throttle_value = n_value[rpd_pkg::CH_THROTTLE];
    assign o_result.hold_value     = n_value[rpd_pkg::CH_HOLD];

endmodule

// File: src/rpd_out_buf.sv
// Output result register of the RC PWM pulse decoder.
module rpd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  rpd_pkg::t_out_word i_word,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_free,
    output rpd_pkg::t_out_word o_word
);

    logic               r_valid;
    rpd_pkg::t_out_word r_word;

    // The register can take a word when empty or when its word leaves now.
    assign o_free = !r_valid || !i_stall;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
